// ===== hdl/gqle_pkg.sv =====
package gqle_pkg;

   localparam int NUM_ACTIONS    = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;

   // command codes
   localparam logic [1:0] CMD_CHOOSE = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEARN_RATE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISCOUNT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPLORE_RATE = 3'd4;

   localparam logic [8:0] RATE_ONE = 9'd256;

   typedef struct packed {
      logic [1:0]         command;
      logic [3:0]         cur_col;
      logic [3:0]         cur_row;
      logic [1:0]         taken_action;
      logic [3:0]         next_col;
      logic [3:0]         next_row;
      logic signed [15:0] reward_value;
      logic [7:0]         random_draw;
      logic [1:0]         random_pick;
   } gqle_req_type;

   typedef struct packed {
      logic [1:0]         chosen_action;
      logic signed [15:0] entry_value;
      logic               goal_reached;
      logic               explored;
   } gqle_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_NEXT,
      ST_READ_CUR,
      ST_GAMMA,
      ST_TARGET,
      ST_BLEND,
      ST_WRITE,
      ST_FETCH,
      ST_SELECT,
      ST_NULL
   } gqle_state_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_CHOOSE,
      RSP_READ,
      RSP_UPDATE,
      RSP_ZERO
   } gqle_reply_type;

   typedef struct packed {
      logic           latch;
      logic           clr_step;
      logic           rd_next;
      logic           rd_cur;
      logic           load_max;
      logic           load_gamma;
      logic           load_target;
      logic           load_blend;
      gqle_reply_type reply;
   } gqle_ctrl_type;

   typedef struct packed {
      logic [1:0] command;
      logic       clr_last;
   } gqle_stat_type;

endpackage

// ===== hdl/grid_q_learning_engine.sv =====
// Tabular Q-learning engine for a grid of up to MAX_COLS x MAX_ROWS cells,
// four Q8.8 action values per cell held in one table memory row per cell.
// Command channel: present req_data with start high; the transaction is taken
// at a clock edge where start is high and busy is low. busy stays high until
// the block can take the next transaction.
// Result channel: one result per transaction, shown on rsp_data for exactly one
// cycle with rsp_valid high. The receiver cannot stall it and must take it then.
// An update steps through the idle state that takes the transaction, two
// table reads on the single read port, the gamma multiply, the target add,
// the blend multiplies and the saturating write back, one state each.
// Choose and read go through a table read state and a select state; an unused
// command goes through a single null state. A new transaction can be taken in
// the cycle the result is shown, but not before the last one is through.
// Configuration: csr_ready is always high; write only while the block is idle.
// Reset: configuration returns to its defaults and the table is cleared one
// cell row per cycle, with busy high until every row is written.
module grid_q_learning_engine import gqle_pkg::*; #(
   parameter int MAX_COLS   = 16,
   parameter int MAX_ROWS   = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  gqle_req_type              req_data,
   output logic                      rsp_valid,
   output gqle_rsp_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   gqle_ctrl_type ctrl;
   gqle_stat_type stat;

   assign csr_ready = 1'b1;

   gqle_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_data.command),
      .stat        (stat),
      .ctrl        (ctrl),
      .busy        (busy)
   );

   gqle_dp #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/gqle_ram.sv =====
module gqle_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gqle_ctrl.sv =====
module gqle_ctrl import gqle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_command,
   input  gqle_stat_type stat,
   output gqle_ctrl_type ctrl,
   output logic          busy
);

   gqle_state_type state_ff;
   gqle_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.reply = RSP_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctrl.latch = 1'b1;
               unique case (req_command)
                  CMD_UPDATE: state_in = ST_READ_NEXT;
                  CMD_CHOOSE: state_in = ST_FETCH;
                  CMD_READ:   state_in = ST_FETCH;
                  default:    state_in = ST_NULL;
               endcase
            end
         end
         ST_READ_NEXT: begin
            ctrl.rd_next = 1'b1;
            state_in     = ST_READ_CUR;
         end
         ST_READ_CUR: begin
            // next-cell row is on the read port now
            ctrl.rd_cur   = 1'b1;
            ctrl.load_max = 1'b1;
            state_in      = ST_GAMMA;
         end
         ST_GAMMA: begin
            ctrl.load_gamma = 1'b1;
            state_in        = ST_TARGET;
         end
         ST_TARGET: begin
            ctrl.load_target = 1'b1;
            state_in         = ST_BLEND;
         end
         ST_BLEND: begin
            ctrl.load_blend = 1'b1;
            state_in        = ST_WRITE;
         end
         ST_WRITE: begin
            ctrl.reply = RSP_UPDATE;
            state_in   = ST_IDLE;
         end
         ST_FETCH: begin
            ctrl.rd_cur = 1'b1;
            state_in    = ST_SELECT;
         end
         ST_SELECT: begin
            ctrl.reply = (stat.command == CMD_CHOOSE) ? RSP_CHOOSE : RSP_READ;
            state_in   = ST_IDLE;
         end
         ST_NULL: begin
            ctrl.reply = RSP_ZERO;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/gqle_dp.sv =====
module gqle_dp import gqle_pkg::*; #(
   parameter int MAX_COLS   = 16,
   parameter int MAX_ROWS   = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gqle_ctrl_type             ctrl,
   output gqle_stat_type             stat,
   input  gqle_req_type              req_data,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic                      rsp_valid,
   output gqle_rsp_type              rsp_data
);

   localparam int V     = VALUE_BITS;
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int ROW_W = NUM_ACTIONS * V;
   localparam int GW    = V + 10;
   localparam int TW    = ((V + 2 > 16) ? V + 2 : 16) + 1;
   localparam int SW    = ((TW > V) ? TW : V) + 12;
   localparam int KW    = V + 10;
   localparam int NW    = TW + 10;

   // configuration registers
   logic [4:0] grid_width_ff;
   logic [4:0] grid_height_ff;
   logic [8:0] learn_rate_ff;
   logic [8:0] discount_ff;
   logic [8:0] explore_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= 5'd16;
         grid_height_ff  <= 5'd16;
         learn_rate_ff   <= 9'd26;
         discount_ff     <= 9'd230;
         explore_rate_ff <= 9'd26;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:   grid_width_ff   <= csr_data[4:0];
            CSR_GRID_HEIGHT:  grid_height_ff  <= csr_data[4:0];
            CSR_LEARN_RATE:   learn_rate_ff   <= csr_data;
            CSR_DISCOUNT:     discount_ff     <= csr_data;
            CSR_EXPLORE_RATE: explore_rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective grid and rates
   logic [4:0] cols_eff;
   logic [4:0] rows_eff;
   logic [8:0] alpha_eff;
   logic [8:0] gamma_eff;
   logic [8:0] eps_eff;
   logic [4:0] cur_c, cur_r, next_c, next_r;
   logic [AW-1:0] cur_addr_in, next_addr_in;
   logic          goal_in;

   always_comb begin
      cols_eff = (grid_width_ff == 5'd0) ? 5'd1 : grid_width_ff;
      if (int'(cols_eff) > MAX_COLS) begin
         cols_eff = 5'(MAX_COLS);
      end
      rows_eff = (grid_height_ff == 5'd0) ? 5'd1 : grid_height_ff;
      if (int'(rows_eff) > MAX_ROWS) begin
         rows_eff = 5'(MAX_ROWS);
      end
      alpha_eff = (learn_rate_ff > RATE_ONE) ? RATE_ONE : learn_rate_ff;
      gamma_eff = (discount_ff > RATE_ONE) ? RATE_ONE : discount_ff;
      eps_eff   = (explore_rate_ff > RATE_ONE) ? RATE_ONE : explore_rate_ff;

      // out-of-grid cells stick to the last column or row
      cur_c  = ({1'b0, req_data.cur_col} >= cols_eff) ? cols_eff - 5'd1
                                                        : {1'b0, req_data.cur_col};
      cur_r  = ({1'b0, req_data.cur_row} >= rows_eff) ? rows_eff - 5'd1
                                                        : {1'b0, req_data.cur_row};
      next_c = ({1'b0, req_data.next_col} >= cols_eff) ? cols_eff - 5'd1
                                                         : {1'b0, req_data.next_col};
      next_r = ({1'b0, req_data.next_row} >= rows_eff) ? rows_eff - 5'd1
                                                         : {1'b0, req_data.next_row};
      cur_addr_in  = AW'(int'(cur_r) * MAX_COLS + int'(cur_c));
      next_addr_in = AW'(int'(next_r) * MAX_COLS + int'(next_c));
      goal_in      = (next_c == cols_eff - 5'd1) && (next_r == rows_eff - 5'd1);
   end

   gqle_req_type  item_ff;
   logic [AW-1:0] cur_addr_ff;
   logic [AW-1:0] next_addr_ff;
   logic          goal_ff;

   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         item_ff      <= req_data;
         cur_addr_ff  <= cur_addr_in;
         next_addr_ff <= next_addr_in;
         goal_ff      <= goal_in;
      end
   end

   // table clear sweep after reset
   logic [AW-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctrl.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign stat.clr_last = (clr_cnt_ff == AW'(CELLS - 1));
   assign stat.command  = item_ff.command;

   // table memory, one row of action values per cell
   logic             ram_we;
   logic [AW-1:0]    ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic             ram_re;
   logic [AW-1:0]    ram_rd_addr;
   logic [ROW_W-1:0] ram_rd_data;
   logic [ROW_W-1:0] new_row;

   assign ram_we      = ctrl.clr_step || (ctrl.reply == RSP_UPDATE);
   assign ram_wr_addr = ctrl.clr_step ? clr_cnt_ff : cur_addr_ff;
   assign ram_wr_data = ctrl.clr_step ? '0 : new_row;
   assign ram_re      = ctrl.rd_next || ctrl.rd_cur;
   assign ram_rd_addr = ctrl.rd_next ? next_addr_ff : cur_addr_ff;

   gqle_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CELLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic signed [V-1:0] rd_entry [NUM_ACTIONS];
   logic signed [V-1:0] max_in;
   logic [1:0]          best;

   always_comb begin
      for (int i = 0; i < NUM_ACTIONS; i++) begin
         rd_entry[i] = ram_rd_data[i*V +: V];
      end
      max_in = rd_entry[0];
      best   = 2'd0;
      // strict compare keeps the lowest index on ties
      for (int i = 1; i < NUM_ACTIONS; i++) begin
         if (rd_entry[i] > max_in) begin
            max_in = rd_entry[i];
            best   = 2'(i);
         end
      end
   end

   // update arithmetic
   logic signed [V-1:0]  maxq_ff;
   logic [ROW_W-1:0]     row_ff;
   logic signed [GW-1:0] gamma_prod;
   logic signed [GW-1:0] gamma_prod_ff;
   logic signed [GW-1:0] g_round;
   logic signed [TW-1:0] target_in;
   logic signed [TW-1:0] target_ff;
   logic [8:0]           keep_rate;
   logic signed [V-1:0]  q_cur;
   logic signed [KW-1:0] keep_prod;
   logic signed [NW-1:0] new_prod;
   logic signed [SW-1:0] keep_ff;
   logic signed [SW-1:0] new_ff;

   assign gamma_prod = GW'($signed({1'b0, gamma_eff})) * GW'(maxq_ff);
   assign g_round    = (gamma_prod_ff + GW'(128)) >>> 8;
   assign target_in  = TW'(item_ff.reward_value) + TW'(g_round);
   assign keep_rate  = RATE_ONE - alpha_eff;
   assign q_cur      = row_ff[item_ff.taken_action*V +: V];
   assign keep_prod  = KW'($signed({1'b0, keep_rate})) * KW'(q_cur);
   assign new_prod   = NW'($signed({1'b0, alpha_eff})) * NW'(target_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load_max) begin
         maxq_ff <= max_in;
      end
      if (ctrl.load_gamma) begin
         row_ff        <= ram_rd_data;
         gamma_prod_ff <= gamma_prod;
      end
      if (ctrl.load_target) begin
         target_ff <= target_in;
      end
      if (ctrl.load_blend) begin
         keep_ff <= SW'(keep_prod);
         new_ff  <= SW'(new_prod);
      end
   end

   logic signed [SW-1:0] blend_sum;
   logic signed [SW-1:0] nv_full;
   logic signed [V-1:0]  new_entry;

   always_comb begin
      blend_sum = keep_ff + new_ff + SW'(128);
      nv_full   = blend_sum >>> 8;
      if ((&nv_full[SW-1:V-1]) || !(|nv_full[SW-1:V-1])) begin
         new_entry = nv_full[V-1:0];
      end else if (nv_full[SW-1]) begin
         new_entry = {1'b1, {(V-1){1'b0}}};
      end else begin
         new_entry = {1'b0, {(V-1){1'b1}}};
      end
      new_row = row_ff;
      new_row[item_ff.taken_action*V +: V] = new_entry;
   end

   // result assembly
   logic signed [V-1:0]  out_src;
   logic signed [15:0]   out16;
   logic                 explore;
   gqle_rsp_type         rsp_in;
   gqle_rsp_type         rsp_data_ff;
   logic                 rsp_valid_ff;

   always_comb begin
      unique case (ctrl.reply)
         RSP_UPDATE: out_src = new_entry;
         RSP_READ:   out_src = rd_entry[item_ff.taken_action];
         default:    out_src = '0;
      endcase
   end

   if (VALUE_BITS > 16) begin : g_sat
      always_comb begin
         if ((&out_src[V-1:15]) || !(|out_src[V-1:15])) begin
            out16 = out_src[15:0];
         end else if (out_src[V-1]) begin
            out16 = 16'sh8000;
         end else begin
            out16 = 16'sh7fff;
         end
      end
   end else begin : g_ext
      assign out16 = 16'(out_src);
   end

   assign explore = ({1'b0, item_ff.random_draw} < eps_eff);

   always_comb begin
      rsp_in = '0;
      unique case (ctrl.reply)
         RSP_CHOOSE: begin
            rsp_in.chosen_action = explore ? item_ff.random_pick : best;
            rsp_in.explored      = explore;
         end
         RSP_READ: begin
            rsp_in.entry_value = out16;
         end
         RSP_UPDATE: begin
            rsp_in.entry_value  = out16;
            rsp_in.goal_reached = goal_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (ctrl.reply != RSP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.reply != RSP_NONE) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/grid_q_learning_engine_checker.sv =====
`timescale 1ns / 1ps

module grid_q_learning_engine_checker import gqle_pkg::*; #(
   parameter int MAX_COLS   = 16,
   parameter int MAX_ROWS   = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  gqle_req_type              req_data,
   input  logic                      rsp_valid,
   input  gqle_rsp_type              rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        failures,
   output int                        outstanding
);

   localparam int TABLE_DEPTH = MAX_COLS * MAX_ROWS * NUM_ACTIONS;

   longint       q_table [0:TABLE_DEPTH-1];
   logic [4:0]   width_reg;
   logic [4:0]   height_reg;
   logic [8:0]   alpha_reg;
   logic [8:0]   gamma_reg;
   logic [8:0]   epsilon_reg;
   gqle_rsp_type pending_rsps [$];
   int           fail_total = 0;

   function automatic longint clip(input longint x, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
         return hi;
      end
      if (x < lo) begin
         return lo;
      end
      return x;
   endfunction

   // zero acts as one, anything past the storage acts as the storage size
   function automatic int used_span(input logic [4:0] size, input int limit);
      if (size == 0) begin
         return 1;
      end
      if (int'(size) > limit) begin
         return limit;
      end
      return int'(size);
   endfunction

   function automatic int pin_coord(input logic [3:0] coord, input int span);
      return (int'(coord) >= span) ? span - 1 : int'(coord);
   endfunction

   function automatic longint rate_of(input logic [8:0] rate);
      return (rate > RATE_ONE) ? longint'(RATE_ONE) : longint'(rate);
   endfunction

   // works out the result of one transaction and applies its table write
   function automatic gqle_rsp_type predict_rsp(input gqle_req_type item);
      gqle_rsp_type rsp;
      int           cols;
      int           rows;
      int           slot;
      int           next_slot;
      int           next_col;
      int           next_row;
      int           best;
      longint       alpha;
      longint       gamma;
      longint       reward;
      longint       max_next;
      longint       target;
      longint       blended;
      rsp  = '0;
      cols = used_span(width_reg, MAX_COLS);
      rows = used_span(height_reg, MAX_ROWS);
      slot = (pin_coord(item.cur_row, rows) * MAX_COLS + pin_coord(item.cur_col, cols))
             * NUM_ACTIONS;
      unique case (item.command)
         CMD_CHOOSE: begin
            if (longint'(item.random_draw) < rate_of(epsilon_reg)) begin
               rsp.chosen_action = item.random_pick;
               rsp.explored      = 1'b1;
            end else begin
               best = 0;
               for (int i = 1; i < NUM_ACTIONS; i++) begin
                  if (q_table[slot + i] > q_table[slot + best]) begin
                     best = i;
                  end
               end
               rsp.chosen_action = best[1:0];
            end
         end
         CMD_UPDATE: begin
            next_col  = pin_coord(item.next_col, cols);
            next_row  = pin_coord(item.next_row, rows);
            next_slot = (next_row * MAX_COLS + next_col) * NUM_ACTIONS;
            alpha     = rate_of(alpha_reg);
            gamma     = rate_of(gamma_reg);
            reward    = longint'(item.reward_value);
            // max is taken before the write, also when both cells are the same
            max_next  = q_table[next_slot];
            for (int i = 1; i < NUM_ACTIONS; i++) begin
               if (q_table[next_slot + i] > max_next) begin
                  max_next = q_table[next_slot + i];
               end
            end
            target  = reward + ((gamma * max_next + 128) >>> 8);
            blended = ((256 - alpha) * q_table[slot + item.taken_action]
                       + alpha * target + 128) >>> 8;
            blended = clip(blended, VALUE_BITS);
            q_table[slot + item.taken_action] = blended;
            rsp.entry_value  = 16'(clip(blended, 16));
            rsp.goal_reached = (next_col == cols - 1) && (next_row == rows - 1);
         end
         CMD_READ: begin
            rsp.entry_value = 16'(clip(q_table[slot + item.taken_action], 16));
         end
         default: begin
            rsp = '0;
         end
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin : watch
      gqle_rsp_type want;
      if (reset) begin
         foreach (q_table[i]) begin
            q_table[i] = 0;
         end
         width_reg   = 5'd16;
         height_reg  = 5'd16;
         alpha_reg   = 9'd26;
         gamma_reg   = 9'd230;
         epsilon_reg = 9'd26;
         pending_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GRID_WIDTH:   width_reg   = csr_data[4:0];
               CSR_GRID_HEIGHT:  height_reg  = csr_data[4:0];
               CSR_LEARN_RATE:   alpha_reg   = csr_data;
               CSR_DISCOUNT:     gamma_reg   = csr_data;
               CSR_EXPLORE_RATE: epsilon_reg = csr_data;
               default: ;
            endcase
         end
         // a result seen at the same edge as a new transaction belongs to an older one
         if (rsp_valid) begin
            if (pending_rsps.size() == 0) begin
               $error("result with no transaction pending: %h", rsp_data);
               fail_total++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_data.chosen_action !== want.chosen_action) begin
                  $error("chosen_action: expected %0d, actual %0d",
                         want.chosen_action, rsp_data.chosen_action);
                  fail_total++;
               end
               if (rsp_data.entry_value !== want.entry_value) begin
                  $error("entry_value: expected %0d, actual %0d",
                         want.entry_value, rsp_data.entry_value);
                  fail_total++;
               end
               if (rsp_data.goal_reached !== want.goal_reached) begin
                  $error("goal_reached: expected %0d, actual %0d",
                         want.goal_reached, rsp_data.goal_reached);
                  fail_total++;
               end
               if (rsp_data.explored !== want.explored) begin
                  $error("explored: expected %0d, actual %0d",
                         want.explored, rsp_data.explored);
                  fail_total++;
               end
            end
         end
         if (start && !busy) begin
            pending_rsps.push_back(predict_rsp(req_data));
         end
      end
      failures    <= fail_total;
      outstanding <= pending_rsps.size();
   end

endmodule

// ===== sim/grid_q_learning_engine_test.sv =====
`timescale 1ns / 1ps

module grid_q_learning_engine_test;
   import gqle_pkg::*;

   localparam int MAX_COLS = 16;
   localparam int MAX_ROWS = 16;

   // command code with no operation behind it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // how an action moves the walker through the grid
   localparam logic [1:0] MOVE_UP    = 2'd0;
   localparam logic [1:0] MOVE_RIGHT = 2'd1;
   localparam logic [1:0] MOVE_DOWN  = 2'd2;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   gqle_req_type              req_data  = '0;
   logic                      rsp_valid;
   gqle_rsp_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;
   int                        failures;
   int                        outstanding;

   int idle_pct  = 28;
   int grid_cols = 16;
   int grid_rows = 16;
   int walk_col  = 0;
   int walk_row  = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   grid_q_learning_engine #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_BITS (16)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   grid_q_learning_engine_checker #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_BITS (16)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   function automatic gqle_req_type req_of(input logic [1:0] command,
                                           input int cur_col, input int cur_row,
                                           input int action,
                                           input int next_col, input int next_row,
                                           input logic [15:0] reward,
                                           input int draw, input int pick);
      gqle_req_type item;
      item.command      = command;
      item.cur_col      = cur_col[3:0];
      item.cur_row      = cur_row[3:0];
      item.taken_action = action[1:0];
      item.next_col     = next_col[3:0];
      item.next_row     = next_row[3:0];
      item.reward_value = reward;
      item.random_draw  = draw[7:0];
      item.random_pick  = pick[1:0];
      return item;
   endfunction

   // mostly episode-like moves through the grid, with some fully random noise
   function automatic gqle_req_type episode_item();
      logic [63:0]  bits;
      gqle_req_type item;
      int           roll;
      int           step_col;
      int           step_row;
      logic         at_goal;
      bits = {$urandom(), $urandom()};
      item = bits[$bits(gqle_req_type)-1:0];
      roll = $urandom_range(99);
      if (roll < 12) begin
         return item;
      end
      item.cur_col = walk_col[3:0];
      item.cur_row = walk_row[3:0];
      if (roll < 45) begin
         item.command = CMD_CHOOSE;
      end else if (roll < 85) begin
         item.command = CMD_UPDATE;
         step_col = walk_col;
         step_row = walk_row;
         unique case (item.taken_action)
            MOVE_UP:    if (step_row > 0) step_row--;
            MOVE_RIGHT: if (step_col < grid_cols - 1) step_col++;
            MOVE_DOWN:  if (step_row < grid_rows - 1) step_row++;
            default:    if (step_col > 0) step_col--;
         endcase
         item.next_col = step_col[3:0];
         item.next_row = step_row[3:0];
         at_goal = (step_col == grid_cols - 1) && (step_row == grid_rows - 1);
         if (at_goal) begin
            item.reward_value = 16'sh0A00;
         end else if (roll < 78) begin
            item.reward_value = 16'shFFF0;
         end
         walk_col = at_goal ? 0 : step_col;
         walk_row = at_goal ? 0 : step_row;
      end else begin
         item.command = CMD_READ;
      end
      return item;
   endfunction

   task automatic issue(input gqle_req_type item);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop issuing and let every pending transaction come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_csrs(input int cols, input int rows, input int alpha,
                               input int gamma, input int epsilon);
      drain();
      // upper data bits of the size registers are don't-care, so toggle them
      write_reg(CSR_GRID_WIDTH,   {4'($urandom_range(15)), cols[4:0]});
      write_reg(CSR_GRID_HEIGHT,  {4'($urandom_range(15)), rows[4:0]});
      write_reg(CSR_LEARN_RATE,   alpha[8:0]);
      write_reg(CSR_DISCOUNT,     gamma[8:0]);
      write_reg(CSR_EXPLORE_RATE, epsilon[8:0]);
      csr_valid <= 1'b0;
      @(posedge clock);
      grid_cols = (cols[4:0] == 0) ? 1 : ((cols[4:0] > MAX_COLS) ? MAX_COLS : cols[4:0]);
      grid_rows = (rows[4:0] == 0) ? 1 : ((rows[4:0] > MAX_ROWS) ? MAX_ROWS : rows[4:0]);
      walk_col  = 0;
      walk_row  = 0;
   endtask

   task automatic run_episodes(input int count);
      repeat (count) issue(episode_item());
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // alpha and gamma at one so values jump straight to the rails
      idle_pct = 28;
      program_csrs(16, 16, 256, 256, 26);
      issue(req_of(CMD_READ,   0, 0, 0,  0,  0, 16'h0000, 0,   0));
      issue(req_of(CMD_CHOOSE, 0, 0, 0,  0,  0, 16'h0000, 255, 2));
      issue(req_of(CMD_CHOOSE, 0, 0, 0,  0,  0, 16'h0000, 0,   3));
      issue(req_of(CMD_CHOOSE, 0, 0, 0,  0,  0, 16'h0000, 25,  1));
      issue(req_of(CMD_CHOOSE, 0, 0, 0,  0,  0, 16'h0000, 26,  1));
      issue(req_of(CMD_UPDATE, 0, 0, 2, 15, 15, 16'h7FFF, 0,   0));
      issue(req_of(CMD_UPDATE, 1, 0, 0,  0,  0, 16'h7FFF, 0,   0));
      issue(req_of(CMD_UPDATE, 2, 0, 1, 14, 15, 16'h8000, 0,   0));
      issue(req_of(CMD_UPDATE, 3, 3, 3,  3,  3, 16'h0100, 0,   0));
      issue(req_of(CMD_UPDATE, 3, 3, 3,  3,  3, 16'h0100, 0,   0));
      issue(req_of(CMD_CHOOSE, 0, 0, 0,  0,  0, 16'h0000, 255, 0));
      issue(req_of(CMD_CHOOSE, 2, 0, 0,  0,  0, 16'h0000, 255, 0));
      issue(req_of(CMD_READ,   0, 0, 2,  0,  0, 16'h0000, 0,   0));
      issue(req_of(CMD_READ,   2, 0, 1,  0,  0, 16'h0000, 0,   0));
      issue(req_of(CMD_UNUSED, 15, 15, 3, 15, 15, 16'hFFFF, 255, 3));

      // zero width and discount, height, learning and explore rates past their ranges
      program_csrs(0, 31, 511, 0, 511);
      issue(req_of(CMD_UPDATE, 9,  9, 1, 15, 15, 16'h0300, 0,   0));
      issue(req_of(CMD_UPDATE, 0,  4, 2,  7,  4, 16'hFD00, 0,   0));
      issue(req_of(CMD_CHOOSE, 4, 12, 0,  0,  0, 16'h0000, 255, 1));
      issue(req_of(CMD_READ,   9, 15, 1,  0,  0, 16'h0000, 0,   0));
      issue(req_of(CMD_READ,  15,  4, 2,  0,  0, 16'h0000, 0,   0));
      run_episodes(100);

      program_csrs(4, 3, 26, 230, 26);
      run_episodes(400);

      idle_pct = 65;
      program_csrs(16, 16, 128, 255, 64);
      run_episodes(400);

      idle_pct = 0;
      program_csrs(7, 16, 1, 256, 0);
      run_episodes(400);

      drain();
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
